### design/bxag_pkg.sv
package bxag_pkg;

	// Limits on the window size and the element size.
	localparam int MAX_DIM        = 4096;
	localparam int MAX_ELEM_BYTES = 16;

	localparam int CNT_W  = 12;   // walk counters
	localparam int DIM_W  = 13;   // window sizes and stride
	localparam int POS_W  = 12;   // start row and column
	localparam int EB_W   = 5;    // element size
	localparam int MODE_W = 3;
	localparam int OFS_W  = 28;   // byte offsets
	localparam int DLIN_W = 25;   // packed element index before scaling

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WALK_MODE     = 3'd6;

	// Bits of walk_mode.
	localparam int MODE_ROW_MAJOR = 0;
	localparam int MODE_ROWS_UP   = 1;
	localparam int MODE_COLS_UP   = 2;

	typedef struct packed {
		logic step;      // take the current element and advance the counters
		logic calc;      // form the unscaled source and packed indexes
		logic load_out;  // scale and load the output register
	} bxag_cmd_t;

	typedef struct packed {
		logic out_busy;  // output register holds a word that is not taken this cycle
	} bxag_stat_t;

endpackage

### design/bxag_ctrl.sv
module bxag_ctrl
	import bxag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_advance,
	output logic       in_ready,
	input  bxag_stat_t stat,
	output bxag_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.step     = 1'b0;
		cmd.calc     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// A word with advance low is taken and dropped.
				if (in_valid && in_advance) begin
					cmd.step = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.calc = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/bxag_dp.sv
module bxag_dp
	import bxag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  bxag_cmd_t             cmd,
	output bxag_stat_t            stat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OFS_W-1:0]      source_offset,
	output logic [OFS_W-1:0]      dest_offset,
	output logic                  last_element
);

	logic [POS_W-1:0]  start_row_q;
	logic [POS_W-1:0]  start_col_q;
	logic [DIM_W-1:0]  window_rows_q;
	logic [DIM_W-1:0]  window_cols_q;
	logic [DIM_W-1:0]  picture_width_q;
	logic [EB_W-1:0]   element_bytes_q;
	logic [MODE_W-1:0] walk_mode_q;

	logic [CNT_W-1:0]  outer_q;
	logic [CNT_W-1:0]  inner_q;

	logic [DIM_W-1:0]  rows;
	logic [DIM_W-1:0]  cols;
	logic [EB_W-1:0]   bytes;
	logic [DIM_W-1:0]  outer_lim;
	logic [DIM_W-1:0]  inner_lim;
	logic [CNT_W-1:0]  row_idx;
	logic [CNT_W-1:0]  col_idx;
	logic [OFS_W-1:0]  row_pos;
	logic [OFS_W-1:0]  col_pos;
	logic              inner_end;
	logic              outer_end;

	logic [OFS_W-1:0]  row_s1;
	logic [OFS_W-1:0]  col_s1;
	logic [CNT_W-1:0]  outer_s1;
	logic [CNT_W-1:0]  inner_s1;
	logic [DIM_W-1:0]  ilim_s1;
	logic              last_s1;

	logic [OFS_W-1:0]  lin_s2;
	logic [DLIN_W-1:0] dlin_s2;
	logic              last_s2;

	logic              out_valid_q;
	logic [OFS_W-1:0]  src_q;
	logic [OFS_W-1:0]  dst_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q     <= '0;
			start_col_q     <= '0;
			window_rows_q   <= DIM_W'(1);
			window_cols_q   <= DIM_W'(1);
			picture_width_q <= DIM_W'(1);
			element_bytes_q <= EB_W'(1);
			walk_mode_q     <= MODE_W'(7);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ROW:     start_row_q     <= cfg_data[POS_W-1:0];
				REG_START_COL:     start_col_q     <= cfg_data[POS_W-1:0];
				REG_WINDOW_ROWS:   window_rows_q   <= cfg_data[DIM_W-1:0];
				REG_WINDOW_COLS:   window_cols_q   <= cfg_data[DIM_W-1:0];
				REG_PICTURE_WIDTH: picture_width_q <= cfg_data[DIM_W-1:0];
				REG_ELEMENT_BYTES: element_bytes_q <= cfg_data[EB_W-1:0];
				REG_WALK_MODE:     walk_mode_q     <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range sizes are clamped; the stride is used as written.
	always_comb begin
		if (window_rows_q == '0) begin
			rows = DIM_W'(1);
		end else if (window_rows_q > DIM_W'(MAX_DIM)) begin
			rows = DIM_W'(MAX_DIM);
		end else begin
			rows = window_rows_q;
		end
		if (window_cols_q == '0) begin
			cols = DIM_W'(1);
		end else if (window_cols_q > DIM_W'(MAX_DIM)) begin
			cols = DIM_W'(MAX_DIM);
		end else begin
			cols = window_cols_q;
		end
		if (element_bytes_q == '0) begin
			bytes = EB_W'(1);
		end else if (element_bytes_q > EB_W'(MAX_ELEM_BYTES)) begin
			bytes = EB_W'(MAX_ELEM_BYTES);
		end else begin
			bytes = element_bytes_q;
		end
	end

	always_comb begin
		if (walk_mode_q[MODE_ROW_MAJOR]) begin
			outer_lim = rows;
			inner_lim = cols;
			row_idx   = outer_q;
			col_idx   = inner_q;
		end else begin
			outer_lim = cols;
			inner_lim = rows;
			row_idx   = inner_q;
			col_idx   = outer_q;
		end
	end

	// Positions wrap modulo the offset width when the walk runs below zero.
	assign row_pos = walk_mode_q[MODE_ROWS_UP]
		? OFS_W'(start_row_q) + OFS_W'(row_idx)
		: OFS_W'(start_row_q) - OFS_W'(row_idx);
	assign col_pos = walk_mode_q[MODE_COLS_UP]
		? OFS_W'(start_col_q) + OFS_W'(col_idx)
		: OFS_W'(start_col_q) - OFS_W'(col_idx);

	// A counter at or past a limit that shrank counts as being at its end.
	assign inner_end = ({1'b0, inner_q} + DIM_W'(1)) >= inner_lim;
	assign outer_end = ({1'b0, outer_q} + DIM_W'(1)) >= outer_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= '0;
			inner_q <= '0;
		end else if (cmd.step) begin
			if (inner_end) begin
				inner_q <= '0;
				outer_q <= outer_end ? '0 : outer_q + CNT_W'(1);
			end else begin
				inner_q <= inner_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			row_s1   <= row_pos;
			col_s1   <= col_pos;
			outer_s1 <= outer_q;
			inner_s1 <= inner_q;
			ilim_s1  <= inner_lim;
			last_s1  <= inner_end && outer_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			lin_s2  <= row_s1 * OFS_W'(picture_width_q) + col_s1;
			dlin_s2 <= DLIN_W'(outer_s1) * DLIN_W'(ilim_s1) + DLIN_W'(inner_s1);
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			src_q  <= lin_s2 * OFS_W'(bytes);
			dst_q  <= OFS_W'(dlin_s2) * OFS_W'(bytes);
			last_q <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign source_offset = src_q;
	assign dest_offset   = dst_q;
	assign last_element  = last_q;

endmodule

### design/block_extract_address_generator.sv
// A word with advance set puts its offsets on m_tdata once the s1, s2 and output registers have each been loaded.
// The controller steps one word through both multiplies before it takes the next; an output
// word not yet taken holds the last step.
// A word with advance clear is taken while the controller is idle and gives no output word.
// Reset (arst_n low, asynchronous) clears the walk counters and loads the register defaults:
// start 0,0, a one by one window, stride 1, one byte per element, row-major ascending walk.
module block_extract_address_generator
	import bxag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] advance, [7:1] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,   // [27:0] source_offset, [55:28] dest_offset
	output logic                  m_tlast    // last_element
);

	bxag_cmd_t  cmd;
	bxag_stat_t stat;
	logic [OFS_W-1:0] source_offset;
	logic [OFS_W-1:0] dest_offset;

	bxag_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_advance (s_tdata[0]),
		.in_ready   (s_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bxag_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.source_offset (source_offset),
		.dest_offset   (dest_offset),
		.last_element  (m_tlast)
	);

	assign m_tdata = {dest_offset, source_offset};

	// The output register is never overwritten while it holds a word not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(m_tvalid && !m_tready))
		else $error("output word overwritten before it was taken");

	// Once a word with advance set is taken, the input side stays closed while it is worked on.
	a_busy_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[0]) |=> !s_tready ##1 !s_tready)
		else $error("input taken while a word is in the datapath");

	// A new output word appears only from a load command.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.load_out))
		else $error("output valid rose without a load");

endmodule

### verif/block_extract_address_generator_test.sv
module block_extract_address_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bxag_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_STEPS  = 1700;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		bit [POS_W-1:0]  start_row;
		bit [POS_W-1:0]  start_col;
		bit [DIM_W-1:0]  rows;
		bit [DIM_W-1:0]  cols;
		bit [DIM_W-1:0]  stride;
		bit [EB_W-1:0]   elem_bytes;
		bit [MODE_W-1:0] mode;
	} walk_cfg_t;

	typedef struct {
		bit [OFS_W-1:0] source;
		bit [OFS_W-1:0] dest;
		bit             last;
	} offsets_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_START_ROW;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [0] advance, [7:1] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [55:0]           m_tdata;        // [27:0] source_offset, [55:28] dest_offset
	logic                  m_tlast;        // last_element

	walk_cfg_t      walk_cfg = '{start_row: 0, start_col: 0, rows: 1, cols: 1, stride: 1,
		elem_bytes: 1, mode: 3'd7};
	bit [CNT_W-1:0] outer_pos = '0;
	bit [CNT_W-1:0] inner_pos = '0;
	bit             advance_words[$];
	offsets_t       due_offsets[$];
	bit             calm = 1'b0;
	int             mismatches = 0;
	int             cycle_count = 0;
	int             advances_sent = 0;

	block_extract_address_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 7);
	endfunction

	function automatic logic [63:0] bound(input logic [63:0] v, input logic [63:0] lo,
		input logic [63:0] hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Offsets of the current element, then one step of the nested walk.
	function automatic void walk_advance();
		logic [63:0] rows, cols, bytes, outer_lim, inner_lim;
		logic [63:0] row_idx, col_idx, row, col, src, dst;
		bit          inner_end, outer_end;
		offsets_t    want;
		rows  = bound(walk_cfg.rows, 1, MAX_DIM);
		cols  = bound(walk_cfg.cols, 1, MAX_DIM);
		bytes = bound(walk_cfg.elem_bytes, 1, MAX_ELEM_BYTES);
		if (walk_cfg.mode[MODE_ROW_MAJOR]) begin
			outer_lim = rows;
			inner_lim = cols;
			row_idx   = outer_pos;
			col_idx   = inner_pos;
		end else begin
			outer_lim = cols;
			inner_lim = rows;
			row_idx   = inner_pos;
			col_idx   = outer_pos;
		end
		row = walk_cfg.mode[MODE_ROWS_UP] ? walk_cfg.start_row + row_idx
			: walk_cfg.start_row - row_idx;
		col = walk_cfg.mode[MODE_COLS_UP] ? walk_cfg.start_col + col_idx
			: walk_cfg.start_col - col_idx;
		src = (row * walk_cfg.stride + col) * bytes;
		dst = (64'(outer_pos) * inner_lim + 64'(inner_pos)) * bytes;
		// A counter left past a shrunken limit counts as being at its end.
		inner_end = (64'(inner_pos) + 64'd1) >= inner_lim;
		outer_end = (64'(outer_pos) + 64'd1) >= outer_lim;
		want.source = src[OFS_W-1:0];
		want.dest   = dst[OFS_W-1:0];
		want.last   = inner_end && outer_end;
		due_offsets.push_back(want);
		if (inner_end) begin
			inner_pos = '0;
			outer_pos = outer_end ? '0 : outer_pos + 1'b1;
		end else begin
			inner_pos = inner_pos + 1'b1;
		end
	endfunction

	// Driver: a new word is offered only once the previous one has been taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready && s_tdata[0])
				walk_advance();
			if (!s_tvalid || s_tready) begin
				if (advance_words.size() != 0 && !idle_now()) begin
					s_tdata  <= {7'b0, advance_words.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every output word is checked against the oldest prediction.
	always @(posedge clk) begin
		offsets_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_offsets.size() == 0) begin
					$display("%0t: unexpected word, expected none, got source %h dest %h last %b",
						$time, m_tdata[27:0], m_tdata[55:28], m_tlast);
					mismatches++;
				end else begin
					want = due_offsets.pop_front();
					if (m_tdata[27:0] !== want.source) begin
						$display("%0t: source_offset expected %h got %h",
							$time, want.source, m_tdata[27:0]);
						mismatches++;
					end
					if (m_tdata[55:28] !== want.dest) begin
						$display("%0t: dest_offset expected %h got %h",
							$time, want.dest, m_tdata[55:28]);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_element expected %b got %b",
							$time, want.last, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic drain();
		while (advance_words.size() != 0 || s_tvalid || due_offsets.size() != 0)
			@(posedge clk);
	endtask

	// Words with advance clear leave nothing to wait for, so give the block a few cycles more.
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_START_ROW:     walk_cfg.start_row  = data[POS_W-1:0];
			REG_START_COL:     walk_cfg.start_col  = data[POS_W-1:0];
			REG_WINDOW_ROWS:   walk_cfg.rows       = data[DIM_W-1:0];
			REG_WINDOW_COLS:   walk_cfg.cols       = data[DIM_W-1:0];
			REG_PICTURE_WIDTH: walk_cfg.stride     = data[DIM_W-1:0];
			REG_ELEMENT_BYTES: walk_cfg.elem_bytes = data[EB_W-1:0];
			REG_WALK_MODE:     walk_cfg.mode       = data[MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_walk(input logic [12:0] srow, input logic [12:0] scol,
		input logic [12:0] rows, input logic [12:0] cols, input logic [12:0] stride,
		input logic [12:0] bytes, input logic [12:0] mode);
		settle();
		set_reg(REG_START_ROW, srow);
		set_reg(REG_START_COL, scol);
		set_reg(REG_WINDOW_ROWS, rows);
		set_reg(REG_WINDOW_COLS, cols);
		set_reg(REG_PICTURE_WIDTH, stride);
		set_reg(REG_ELEMENT_BYTES, bytes);
		set_reg(REG_WALK_MODE, mode);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_words(input bit [7:0] pattern, input int n);
		for (int i = 0; i < n; i++) begin
			advance_words.push_back(pattern[i]);
			if (pattern[i])
				advances_sent++;
		end
	endtask

	// n advancing words with an occasional idle word mixed in.
	task automatic queue_random(input int n);
		int taken;
		taken = 0;
		while (taken < n) begin
			if ($urandom_range(9) == 0) begin
				advance_words.push_back(1'b0);
			end else begin
				advance_words.push_back(1'b1);
				advances_sent++;
				taken++;
			end
		end
	endtask

	function automatic logic [12:0] pick_dim();
		case ($urandom_range(19))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'd8191;
			3: return 13'($urandom_range(4097, 8191));
			4: return 13'($urandom());
			default: return 13'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [12:0] pick_stride();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'd8191;
			default: return 13'($urandom());
		endcase
	endfunction

	function automatic logic [12:0] pick_bytes();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd16;
			2: return 13'd31;
			3: return 13'($urandom());
			default: return 13'($urandom_range(1, 16));
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		int random_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: a one element window at offset zero, plus an idle word.
		push_words(8'b101, 3);
		// Zero window rows and element size, zero stride, column-major walk going downward
		// from the origin so that the source offset wraps below zero.
		program_walk(13'd0, 13'd0, 13'd0, 13'd3, 13'd0, 13'd0, 13'd0);
		push_words(8'b111, 3);
		// Everything at its top, with bit 12 set on the start positions; the source offset overflows.
		program_walk(13'h1FFF, 13'h1FFF, 13'd8191, 13'd8191, 13'd8191, 13'd31, 13'd7);
		push_words(8'b11, 2);
		// Full walk of a two by two window with rows descending.
		program_walk(13'd2, 13'd3, 13'd2, 13'd2, 13'd4096, 13'd16, 13'd5);
		push_words(8'b1111, 4);
		// Leave the walk partway, then shrink the window under the counters.
		program_walk(13'd10, 13'd10, 13'd3, 13'd3, 13'd100, 13'd2, 13'd6);
		push_words(8'b11, 2);
		program_walk(13'd10, 13'd10, 13'd1, 13'd1, 13'd100, 13'd2, 13'd3);
		push_words(8'b11, 2);
		program_walk(13'd4000, 13'd1, 13'd2, 13'd2, 13'd4095, 13'd3, 13'd2);
		push_words(8'b11, 2);
		program_walk(13'd1, 13'd4000, 13'd2, 13'd2, 13'd4097, 13'd17, 13'd4);
		push_words(8'b110, 3);

		phase = 0;
		random_start = advances_sent;
		while (advances_sent - random_start < RANDOM_STEPS) begin
			program_walk(13'($urandom()), 13'($urandom()), pick_dim(), pick_dim(),
				pick_stride(), pick_bytes(), 13'($urandom_range(7)));
			calm = (phase == 4);
			n = calm ? 250 : $urandom_range(10, 50);
			queue_random(n);
			if (phase % 7 == 2) begin
				// Hold the sender back until every pending word has come out.
				drain();
				queue_random(n);
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### block_extract_address_generator.f
design/bxag_pkg.sv
design/bxag_ctrl.sv
design/bxag_dp.sv
design/block_extract_address_generator.sv
verif/block_extract_address_generator_test.sv
